>>> rtl/rrip_signature_stream_replacement_unit_macros.svh
// assertion macros for the rrip replacement unit
// no dependencies
`ifndef RRIP_SIGNATURE_STREAM_REPLACEMENT_UNIT_MACROS_SVH
`define RRIP_SIGNATURE_STREAM_REPLACEMENT_UNIT_MACROS_SVH
// assert that a implies b on the same edge
`define RSR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define RSR_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> rtl/rrip_pkg.sv
// types and constants of the rrip replacement unit
// no dependencies
package rrip_pkg;
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int LEADER_SETS = 64;
    localparam int SET_W       = 11;
    localparam int WAY_W       = 4;
    localparam int AGE_ROW_W   = 2 * NUM_WAYS;
    localparam int BLK_W       = 42;
    localparam int STRIDE_W    = 32;
    localparam int RUN_W       = 8;
    localparam int DET_W       = BLK_W + STRIDE_W + RUN_W + 1;
    localparam int PC_DEPTH    = 64;
    localparam int ADDR_DEPTH  = 1024;
    localparam int CLR_W       = 11;
    localparam logic [9:0] DUEL_MID = 10'd512;
    localparam logic [9:0] DUEL_TOP = 10'd1023;
    localparam logic       CMD_QUERY  = 1'b0;
    localparam logic       CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [47:0] phys_addr;
        logic [47:0] prog_counter;
        logic        is_hit;
        logic [4:0]  rand_draw;
    } t_in_beat;

    typedef struct packed {
        logic [4:0] victim_way;
        logic       bypass;
        logic       set_streaming;
    } t_out_beat;
endpackage

>>> rtl/rrip_signature_stream_replacement_unit.sv
// top level of the rrip replacement unit: set memories, reuse tables, duel counter
// depends on rrip_pkg and the assertion macro header
`include "rrip_signature_stream_replacement_unit_macros.svh"
// rrip replacement policy for a last-level cache. each beat on the input
// channel is a victim query or an access update and yields exactly one beat
// on the output channel. on accept the set's age row, stream detector and both
// reuse counters are read from synchronous memories; the execute state then
// modifies, writes back and registers the result, waiting while the output is
// stalled. items are taken one at a time; the output register lets the next
// item be accepted while a result waits. after reset a clearing pass of 2048
// sets, one set a cycle, writes the reset ages, detector state and reuse
// counters while no item is accepted. the duel counter is a register.
module rrip_signature_stream_replacement_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrip_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrip_pkg::t_out_beat o_out_data
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // set memories
    logic [rrip_pkg::AGE_ROW_W-1:0] age_mem [rrip_pkg::NUM_SETS];
    logic [rrip_pkg::DET_W-1:0]     det_mem [rrip_pkg::NUM_SETS];
    logic [rrip_pkg::AGE_ROW_W-1:0] age_rd;
    logic [rrip_pkg::DET_W-1:0]     det_rd;

    // reuse counter memories and their read data
    logic [1:0]  pc_mem [rrip_pkg::PC_DEPTH];
    logic [1:0]  ad_mem [rrip_pkg::ADDR_DEPTH];
    logic [1:0]  pc_v, ad_v;
    logic [9:0]  r_duel;

    logic [1:0]                r_state;
    logic [rrip_pkg::CLR_W:0]  r_clr;
    rrip_pkg::t_in_beat        r_item;
    logic                      r_out_valid;
    rrip_pkg::t_out_beat       r_out;

    logic accept, out_free;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // hashes of the incoming beat, used as read addresses
    logic [5:0] in_ps;
    logic [9:0] in_as;
    assign in_ps = i_in_data.prog_counter[5:0] ^ i_in_data.prog_counter[11:6]
                 ^ i_in_data.prog_counter[17:12];
    assign in_as = i_in_data.phys_addr[15:6] ^ i_in_data.phys_addr[21:12];

    // hashes of the held item
    logic [5:0] ps;
    logic [9:0] as;
    assign ps = r_item.prog_counter[5:0] ^ r_item.prog_counter[11:6]
              ^ r_item.prog_counter[17:12];
    assign as = r_item.phys_addr[15:6] ^ r_item.phys_addr[21:12];

    // detector fields of the row
    logic [rrip_pkg::BLK_W-1:0]    d_last;
    logic [rrip_pkg::STRIDE_W-1:0] d_stride;
    logic [rrip_pkg::RUN_W-1:0]    d_run;
    logic                          d_flag;
    assign {d_last, d_stride, d_run, d_flag} = det_rd;

    // query: age the row and pick the first way at 3
    logic [1:0] maxa, add;
    logic [rrip_pkg::AGE_ROW_W-1:0] aged_row;
    logic [4:0] victim;
    logic       qbyp;
    always_comb begin
        maxa = 2'd0;
        for (int w = 0; w < rrip_pkg::NUM_WAYS; w++) begin
            if (age_rd[2*w +: 2] > maxa) maxa = age_rd[2*w +: 2];
        end
        add = 2'd3 - maxa;
        for (int w = 0; w < rrip_pkg::NUM_WAYS; w++) begin
            aged_row[2*w +: 2] = age_rd[2*w +: 2] + add;
        end
        victim = 5'd0;
        for (int w = rrip_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (aged_row[2*w +: 2] == 2'd3) victim = 5'(w);
        end
        qbyp = d_flag && (pc_v == 2'd0) && (ad_v == 2'd0);
    end

    // update: detector training and insertion age from hit, trained flag, reuse counters and duel
    logic [rrip_pkg::BLK_W-1:0]    blk;
    logic [rrip_pkg::STRIDE_W-1:0] stride, n_stride;
    logic [rrip_pkg::RUN_W-1:0]    n_run;
    logic                          n_flag, high, brrip, lead, lead_b;
    logic [1:0]                    ins_age;
    logic [rrip_pkg::AGE_ROW_W-1:0] upd_row;
    always_comb begin
        blk    = r_item.phys_addr[47:6];
        stride = rrip_pkg::STRIDE_W'(blk - d_last);
        if (d_run != '0 && stride == d_stride) begin
            n_stride = d_stride;
            n_run    = (d_run == 8'd255) ? d_run : d_run + 8'd1;
        end else begin
            n_stride = stride;
            n_run    = 8'd1;
        end
        if (n_run >= 8'd8 && n_stride != '0) n_flag = 1'b1;
        else if (n_run < 8'd4)               n_flag = 1'b0;
        else                                 n_flag = d_flag;
        lead   = r_item.set_index < rrip_pkg::SET_W'(rrip_pkg::LEADER_SETS);
        lead_b = r_item.set_index >= rrip_pkg::SET_W'(rrip_pkg::LEADER_SETS / 2);
        brrip  = lead ? lead_b : (r_duel >= rrip_pkg::DUEL_MID);
        high   = pc_v[1] || ad_v[1];
        if (r_item.is_hit)         ins_age = 2'd0;
        else if (n_flag && !high)  ins_age = 2'd3;
        else if (high)             ins_age = 2'd0;
        else if (brrip)            ins_age = (r_item.rand_draw == 5'd0) ? 2'd2 : 2'd3;
        else                       ins_age = 2'd2;
        upd_row = age_rd;
        upd_row[2*r_item.way_index +: 2] = ins_age;
    end

    // memory ports; writes in the execute cycle repeat the same value while
    // the result waits, since the read data only changes on accept
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            age_mem[r_clr[rrip_pkg::CLR_W-1:0]] <= '1;
            det_mem[r_clr[rrip_pkg::CLR_W-1:0]] <= '0;
            pc_mem[r_clr[5:0]] <= 2'd1;
            ad_mem[r_clr[9:0]] <= 2'd1;
        end else if (r_state == ST_EXEC) begin
            if (r_item.cmd == rrip_pkg::CMD_QUERY) begin
                if (!qbyp) age_mem[r_item.set_index] <= aged_row;
            end else begin
                age_mem[r_item.set_index] <= upd_row;
                det_mem[r_item.set_index] <= {blk, n_stride, n_run, n_flag};
                if (r_item.is_hit) begin
                    if (pc_v != 2'd3) pc_mem[ps] <= pc_v + 2'd1;
                    if (ad_v != 2'd3) ad_mem[as] <= ad_v + 2'd1;
                end else begin
                    pc_mem[ps] <= 2'd1;
                    ad_mem[as] <= 2'd1;
                end
            end
        end
        if (accept) begin
            age_rd <= age_mem[i_in_data.set_index];
            det_rd <= det_mem[i_in_data.set_index];
            pc_v   <= pc_mem[in_ps];
            ad_v   <= ad_mem[in_as];
        end
    end

    // control, duel counter and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_duel      <= rrip_pkg::DUEL_MID;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (rrip_pkg::CLR_W+1)'(rrip_pkg::NUM_SETS - 1))
                        r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_item  <= i_in_data;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        if (r_item.cmd == rrip_pkg::CMD_QUERY) begin
                            r_out.victim_way    <= qbyp ? 5'(rrip_pkg::NUM_WAYS) : victim;
                            r_out.bypass        <= qbyp;
                            r_out.set_streaming <= d_flag;
                        end else begin
                            r_out.victim_way    <= 5'd0;
                            r_out.bypass        <= 1'b0;
                            r_out.set_streaming <= n_flag;
                            if (r_item.is_hit && lead) begin
                                if (!lead_b) begin
                                    if (r_duel != rrip_pkg::DUEL_TOP)
                                        r_duel <= r_duel + 10'd1;
                                end else if (r_duel != 10'd0) begin
                                    r_duel <= r_duel - 10'd1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `RSR_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !accept)
    `RSR_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == ST_EXEC)
    `RSR_ASSERT_IMP(a_bypass_way, i_clk, i_rst_n, r_out_valid && r_out.bypass,
        r_out.victim_way == 5'(rrip_pkg::NUM_WAYS))
endmodule
